/* design/pwle_pkg.sv */
// ----------------------------------------------------------------------------
// pwle_pkg
// shared types and constants of the piecewise linear envelope generator
// ----------------------------------------------------------------------------
`default_nettype none

package pwle_pkg;

  localparam int unsigned VAL_W   = 16;
  localparam int unsigned TIME_W  = 31;
  // quotient bits of the interpolation divide: |b-a|*(off+1)/w <= |b-a| < 2^17
  localparam int unsigned QUO_W   = 17;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sd32767;
  localparam logic signed [VAL_W-1:0] VAL_MIN = -16'sd32767;

  // command codes on the input
  localparam logic [1:0] CMD_SMOOTH = 2'd0;
  localparam logic [1:0] CMD_ROUGH  = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // status codes on the result
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BAD_W   = 2'd2;

  typedef enum logic [1:0] {
    OP_SMOOTH,
    OP_ROUGH,
    OP_QUERY,
    OP_NOP
  } op_t;

  // classified request handed from front to back
  typedef struct packed {
    op_t                      op;
    logic [TIME_W-1:0]        width;
    logic signed [VAL_W-1:0]  sv;
    logic signed [VAL_W-1:0]  ev;
    logic [TIME_W-1:0]        qtime;
  } req_t;

  // one stored segment
  typedef struct packed {
    logic [TIME_W-1:0]        width;
    logic                     rough;
    logic signed [VAL_W-1:0]  sv;
    logic signed [VAL_W-1:0]  ev;
  } seg_t;

  // front/back queue handshake
  typedef struct packed {
    logic valid;
    req_t req;
  } head_t;

endpackage

`default_nettype wire

/* design/pwle_front.sv */
// ----------------------------------------------------------------------------
// pwle_front
// accepts requests, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
`default_nettype none

module pwle_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire  [1:0]           in_cmd,
  input  wire  [30:0]          in_seg_width,
  input  wire  signed [15:0]   in_start_value,
  input  wire  signed [15:0]   in_end_value,
  input  wire  [30:0]          in_query_time,
  output pwle_pkg::head_t      head,
  input  wire                  pop
);

  pwle_pkg::req_t q_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           push;
  pwle_pkg::req_t req;

  // -32768 folds onto -32767
  function automatic logic signed [15:0] fold(input logic signed [15:0] v);
    return (v < pwle_pkg::VAL_MIN) ? pwle_pkg::VAL_MIN : v;
  endfunction

  always_comb begin
    req.width = in_seg_width;
    req.sv    = 16'sd0;
    req.ev    = fold(in_end_value);
    req.qtime = in_query_time;
    unique case (in_cmd)
      pwle_pkg::CMD_SMOOTH: req.op = pwle_pkg::OP_SMOOTH;
      pwle_pkg::CMD_ROUGH: begin
        req.op = pwle_pkg::OP_ROUGH;
        req.sv = fold(in_start_value);
      end
      pwle_pkg::CMD_QUERY:  req.op = pwle_pkg::OP_QUERY;
      default:              req.op = pwle_pkg::OP_NOP;
    endcase
  end

  assign busy       = (cnt_r == 2'd2);
  assign push       = start && !busy;
  assign head.valid = (cnt_r != 2'd0);
  assign head.req   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        q_r[wr_ptr_r] <= req;
        wr_ptr_r      <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

/* design/pwle_back.sv */
// ----------------------------------------------------------------------------
// pwle_back
// segment table, table walk and interpolation with a bit-serial divider
// ----------------------------------------------------------------------------
`default_nettype none

module pwle_back #(
  parameter int unsigned MAX_SEGMENTS = 63
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  pwle_pkg::head_t      head,
  output logic                 pop,
  output logic                 out_strobe,
  output logic signed [15:0]   out_level,
  output logic [1:0]           out_status
);

  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned QW = pwle_pkg::QUO_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QSTART,
    S_WALK,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  state_t              state_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       k_r;
  logic [30:0]         t_r;
  logic [30:0]         base_r;
  logic signed [15:0]  prev_end_r;
  logic signed [15:0]  a_r;
  logic signed [15:0]  b_r;
  logic [30:0]         w_r;
  logic [30:0]         off_r;
  logic signed [49:0]  prod_r;
  logic [30:0]         rem_r;
  logic [QW-1:0]       qsh_r;
  logic                neg_r;
  logic [4:0]          itr_r;
  logic                strobe_r;
  logic signed [15:0]  level_r;
  logic [1:0]          status_r;

  pwle_pkg::seg_t      mem [MAX_SEGMENTS];
  pwle_pkg::seg_t      rd_q;
  pwle_pkg::seg_t      wr_data;
  logic                wr_en;
  logic [IW-1:0]       rd_addr;

  logic                is_append;
  logic                hit;
  logic [31:0]         base_sum;
  logic [30:0]         t_off;
  logic signed [16:0]  diff;
  logic [32:0]         offp1;
  logic [49:0]         mag;
  logic [31:0]         trial;
  logic                qbit;
  logic signed [18:0]  sq;
  logic signed [18:0]  rsum;

  assign pop       = (state_r == S_IDLE) && head.valid;
  assign is_append = (head.req.op == pwle_pkg::OP_SMOOTH) ||
                     (head.req.op == pwle_pkg::OP_ROUGH);
  assign wr_en     = pop && is_append && (head.req.width != 31'd0) &&
                     (count_r < CW'(MAX_SEGMENTS));

  always_comb begin
    wr_data.width = head.req.width;
    wr_data.rough = (head.req.op == pwle_pkg::OP_ROUGH);
    wr_data.sv    = head.req.sv;
    wr_data.ev    = head.req.ev;
  end

  assign rd_addr = (k_r < CW'(MAX_SEGMENTS)) ? k_r[IW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IW-1:0]] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // walk datapath: rd_q holds the entry at index k_r - 1
  assign t_off    = t_r - base_r;
  assign hit      = (t_r >= base_r) && (t_off < rd_q.width);
  assign base_sum = {1'b0, base_r} + {1'b0, rd_q.width};

  assign diff  = {b_r[15], b_r} - {a_r[15], a_r};
  assign offp1 = {2'b00, off_r} + 33'd1;
  assign mag   = prod_r[49] ? 50'(-prod_r) : 50'(prod_r);

  assign trial = {rem_r, qsh_r[QW-1]};
  assign qbit  = (trial >= {1'b0, w_r});

  assign sq   = neg_r ? -$signed({2'b00, qsh_r}) : $signed({2'b00, qsh_r});
  assign rsum = {{3{a_r[15]}}, a_r} + sq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (head.valid) begin
            level_r  <= 16'sd0;
            status_r <= pwle_pkg::ST_OK;
            case (head.req.op)
              pwle_pkg::OP_SMOOTH, pwle_pkg::OP_ROUGH: begin
                strobe_r <= 1'b1;
                if (head.req.width == 31'd0) begin
                  status_r <= pwle_pkg::ST_BAD_W;
                end else if (count_r >= CW'(MAX_SEGMENTS)) begin
                  status_r <= pwle_pkg::ST_FULL;
                end else begin
                  count_r <= count_r + CW'(1);
                end
              end
              pwle_pkg::OP_QUERY: begin
                t_r        <= head.req.qtime;
                base_r     <= 31'd0;
                prev_end_r <= 16'sd0;
                k_r        <= '0;
                state_r    <= S_QSTART;
              end
              default: strobe_r <= 1'b1;
            endcase
          end
        end
        S_QSTART: begin
          if (count_r == '0) begin
            strobe_r <= 1'b1;
            state_r  <= S_IDLE;
          end else begin
            k_r     <= k_r + CW'(1);
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          if (hit) begin
            a_r     <= rd_q.rough ? rd_q.sv : prev_end_r;
            b_r     <= rd_q.ev;
            w_r     <= rd_q.width;
            off_r   <= t_off;
            state_r <= S_MUL;
          end else begin
            prev_end_r <= rd_q.ev;
            base_r     <= base_sum[31] ? 31'h7FFF_FFFF : base_sum[30:0];
            if (k_r == count_r) begin
              level_r  <= rd_q.ev;
              strobe_r <= 1'b1;
              state_r  <= S_IDLE;
            end else begin
              k_r <= k_r + CW'(1);
            end
          end
        end
        S_MUL: begin
          prod_r  <= 50'(diff * $signed(offp1));
          state_r <= S_DIV;
          itr_r   <= 5'd0;
        end
        S_DIV: begin
          if (itr_r == 5'd0) begin
            // quotient < 2^17, so the top bits alone are already below w
            neg_r <= prod_r[49];
            rem_r <= mag[47:QW];
            qsh_r <= mag[QW-1:0];
            itr_r <= 5'(QW);
          end else begin
            rem_r <= qbit ? 31'(trial - {1'b0, w_r}) : trial[30:0];
            qsh_r <= {qsh_r[QW-2:0], qbit};
            itr_r <= itr_r - 5'd1;
            if (itr_r == 5'd1) begin
              state_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (rsum > 19'(pwle_pkg::VAL_MAX)) begin
            level_r <= pwle_pkg::VAL_MAX;
          end else if (rsum < 19'(pwle_pkg::VAL_MIN)) begin
            level_r <= pwle_pkg::VAL_MIN;
          end else begin
            level_r <= rsum[15:0];
          end
          strobe_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe = strobe_r;
  assign out_level  = level_r;
  assign out_status = status_r;

endmodule

`default_nettype wire

/* design/piecewise_linear_envelope_top.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_envelope_top
// piecewise linear envelope generator: segment appends and level queries
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low; a two-entry queue
// sits between the request side and the execution side, so busy rises only
// when two requests are waiting. every request gives exactly one result,
// shown for one cycle with out_strobe high; there is no way to hold results
// off, so the receiver must take each one as it comes. an append's result
// is registered as the request leaves the queue head. a query goes through
// a start step, a walk over the segments (one table read per cycle), a
// multiply, the bit-serial divide and a final clamp; a query past the end
// returns the last end value straight from the walk. the segment table is
// a plain memory with no clearing pass, only entries below the segment
// count are ever used
`default_nettype none

module piecewise_linear_envelope_top #(
  parameter int unsigned MAX_SEGMENTS = 63
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire  [1:0]          in_cmd,
  input  wire  [30:0]         in_seg_width,
  input  wire  signed [15:0]  in_start_value,
  input  wire  signed [15:0]  in_end_value,
  input  wire  [30:0]         in_query_time,
  output logic                out_strobe,
  output logic signed [15:0]  out_level,
  output logic [1:0]          out_status
);

  // queue head toward the back end, and its pop
  pwle_pkg::head_t head;
  logic            pop;

  // front: classify and queue requests
  pwle_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_seg_width   (in_seg_width),
    .in_start_value (in_start_value),
    .in_end_value   (in_end_value),
    .in_query_time  (in_query_time),
    .head           (head),
    .pop            (pop)
  );

  // back: table, walk, interpolation
  pwle_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_level  (out_level),
    .out_status (out_status)
  );

  // failed appends report level zero
  a_err_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != pwle_pkg::ST_OK) |-> out_level == 16'sd0)
    else $error("nonzero level on failed append");

  // level stays inside the clamp range
  a_level_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_level != 16'sh8000)
    else $error("level outside clamp range");

  // queue is not full (busy low) right after reset
  a_rst_busy: assert property (@(posedge clk)
    !rst_n |=> !busy)
    else $error("busy after reset");

  // no pop from an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop of empty queue");

endmodule

`default_nettype wire

/* verif/piecewise_linear_envelope_top_tb.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_envelope_top_tb
// self-checking bench for the envelope generator: appends, queries, errors
// ----------------------------------------------------------------------------
// requests are queued by the stimulus process and driven at the falling edge
// by a clocked driver; results are sampled at the rising edge and compared
// with a predicted level and status in request order
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_envelope_top_tb;

  localparam int unsigned NSEG = 63;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [1:0]         cmd;
    logic [30:0]        width;
    logic signed [15:0] sv;
    logic signed [15:0] ev;
    logic [30:0]        qtime;
  } env_req_t;

  typedef struct {
    logic signed [15:0] level;
    logic [1:0]         status;
  } env_res_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_cmd;
  logic [30:0] in_seg_width;
  logic signed [15:0] in_start_value;
  logic signed [15:0] in_end_value;
  logic [30:0] in_query_time;
  logic out_strobe;
  logic signed [15:0] out_level;
  logic [1:0] out_status;

  piecewise_linear_envelope_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_seg_width(in_seg_width),
    .in_start_value(in_start_value), .in_end_value(in_end_value),
    .in_query_time(in_query_time), .out_strobe(out_strobe),
    .out_level(out_level), .out_status(out_status)
  );

  // predictor copy of the segment table
  logic [30:0] seg_w [NSEG];
  logic        seg_rough [NSEG];
  int          seg_a [NSEG];
  int          seg_b [NSEG];
  int unsigned seg_n = 0;

  env_req_t pending_reqs[$];
  env_res_t expected_results[$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct;
  // request taken at the last rising edge
  bit took_req = 1'b0;

  function automatic int clip_val(logic signed [15:0] v);
    return (v == -16'sd32768) ? -32767 : int'(v);
  endfunction

  function automatic logic [1:0] store_segment(logic rough, env_req_t r);
    if (r.width == 0) return pwle_pkg::ST_BAD_W;
    if (seg_n >= NSEG) return pwle_pkg::ST_FULL;
    seg_w[seg_n] = r.width;
    seg_rough[seg_n] = rough;
    seg_a[seg_n] = rough ? clip_val(r.sv) : 0;
    seg_b[seg_n] = clip_val(r.ev);
    seg_n++;
    return pwle_pkg::ST_OK;
  endfunction

  function automatic int interpolate_level(logic [30:0] t);
    longint unsigned base;
    longint a, b, w, off, r;
    int unsigned k;
    base = 0;
    for (k = 0; k < seg_n; k++) begin
      if (t >= base && t - base < seg_w[k]) break;
      base = base + seg_w[k];
      if (base > 64'h7FFF_FFFF) base = 64'h7FFF_FFFF;
    end
    if (k >= seg_n) return (seg_n == 0) ? 0 : seg_b[seg_n-1];
    if (seg_rough[k]) a = seg_a[k];
    else if (k == 0) a = 0;
    else a = seg_b[k-1];
    b = seg_b[k];
    w = seg_w[k];
    off = t - base;
    r = a + ((b - a) * (off + 1)) / w;
    if (r < -32767) r = -32767;
    else if (r > 32767) r = 32767;
    return int'(r);
  endfunction

  function automatic env_res_t predict_result(env_req_t r);
    env_res_t res;
    res.level = 0;
    res.status = pwle_pkg::ST_OK;
    case (r.cmd)
      pwle_pkg::CMD_SMOOTH: res.status = store_segment(1'b0, r);
      pwle_pkg::CMD_ROUGH:  res.status = store_segment(1'b1, r);
      pwle_pkg::CMD_QUERY:  res.level = 16'(interpolate_level(r.qtime));
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // driver: present queued requests at the falling edge, idle at random
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !took_req) begin
      // request not yet taken, hold it
    end else begin
      if (start) void'(pending_reqs.pop_front());
      if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        in_cmd <= pending_reqs[0].cmd;
        in_seg_width <= pending_reqs[0].width;
        in_start_value <= pending_reqs[0].sv;
        in_end_value <= pending_reqs[0].ev;
        in_query_time <= pending_reqs[0].qtime;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // predict on acceptance, check on strobe
  always @(posedge clk) begin
    env_req_t r;
    env_res_t want;
    cycle_count <= cycle_count + 1;
    took_req = rst_n && start && !busy;
    if (took_req) begin
      r.cmd = in_cmd; r.width = in_seg_width; r.sv = in_start_value;
      r.ev = in_end_value; r.qtime = in_query_time;
      expected_results.push_back(predict_result(r));
    end
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_level !== want.level) report_mismatch("level", out_level, want.level);
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
      end
    end
  end

  // timeout watchdog
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL piecewise_linear_envelope_top");
      $finish;
    end
  end

  task automatic queue_req(logic [1:0] c, logic [30:0] w, logic signed [15:0] a,
                           logic signed [15:0] b, logic [30:0] t);
    env_req_t r;
    r.cmd = c; r.width = w; r.sv = a; r.ev = b; r.qtime = t;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || start || expected_results.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // random mix of smooth and rough appends, queries and unused commands
  task automatic queue_random(int n, int unsigned max_w);
    int sel;
    logic [30:0] w;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      w = (sel < 5) ? 31'($urandom) : 31'($urandom_range(max_w));
      if (sel < 30)
        queue_req(pwle_pkg::CMD_SMOOTH, w, 16'($urandom), 16'($urandom), 31'($urandom));
      else if (sel < 50)
        queue_req(pwle_pkg::CMD_ROUGH, w, 16'($urandom), 16'($urandom), 31'($urandom));
      else if (sel < 97)
        queue_req(pwle_pkg::CMD_QUERY, 31'($urandom), 16'($urandom), 16'($urandom),
                  (sel < 60) ? 31'($urandom) : 31'($urandom_range(max_w * 20)));
      else
        queue_req(pwle_pkg::OP_NOP, 31'($urandom), 16'($urandom), 16'($urandom),
                  31'($urandom));
    end
  endtask

  initial begin
    idle_pct = 0;
    rst_n = 0; start = 0; in_cmd = 0; in_seg_width = 0;
    in_start_value = 0; in_end_value = 0; in_query_time = 0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1;

    // directed: empty table, extremes, zero width, -32768 clipping, unused cmd
    queue_req(pwle_pkg::CMD_QUERY, 0, 0, 0, 31'h7FFF_FFFF);
    queue_req(pwle_pkg::CMD_QUERY, 0, 0, 0, 0);
    queue_req(pwle_pkg::CMD_SMOOTH, 0, 0, 16'sd100, 0);
    queue_req(pwle_pkg::CMD_ROUGH, 0, 16'sd5, 16'sd100, 0);
    queue_req(pwle_pkg::OP_NOP, 31'h7FFF_FFFF, -16'sd1, -16'sd1, 31'h7FFF_FFFF);
    queue_req(pwle_pkg::CMD_SMOOTH, 1, 16'sh7FFF, 16'sh7FFF, 0);
    queue_req(pwle_pkg::CMD_ROUGH, 31'h7FFF_FFFF, -16'sd32768, 16'sh7FFF, 0);
    queue_req(pwle_pkg::CMD_SMOOTH, 31'h7FFF_FFFF, 0, -16'sd32768, 0);
    queue_req(pwle_pkg::CMD_ROUGH, 7, -16'sd32767, 16'sd32767, 0);
    queue_req(pwle_pkg::CMD_QUERY, 0, 0, 0, 0);
    queue_req(pwle_pkg::CMD_QUERY, 0, 0, 0, 1);
    queue_req(pwle_pkg::CMD_QUERY, 0, 0, 0, 31'h4000_0000);
    queue_req(pwle_pkg::CMD_QUERY, 0, 0, 0, 31'h7FFF_FFFE);
    queue_req(pwle_pkg::CMD_QUERY, 0, 0, 0, 31'h7FFF_FFFF);
    // pause until the directed part has fully drained
    wait_drained();
    // fill the table to the top, then check the full status and queries
    for (int i = 0; i < 66; i++)
      queue_req((i % 2) ? pwle_pkg::CMD_ROUGH : pwle_pkg::CMD_SMOOTH,
                31'($urandom_range(1, 9)), 16'($urandom), 16'($urandom), 0);
    queue_req(pwle_pkg::CMD_SMOOTH, 0, 0, 0, 0);
    for (int i = 0; i < 10; i++)
      queue_req(pwle_pkg::CMD_QUERY, 0, 0, 0, 31'($urandom_range(700)));
    queue_random(140, 40);

    // phases with different sender idling; table state carries over
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      idle_pct = (ph == 1) ? 66 : (ph == 2) ? 9 : 0;
      queue_random(270, (ph == 3) ? 2000 : 30);
    end
    wait_drained();
    if (err_count == 0) begin
      $display("PASS piecewise_linear_envelope_top");
    end else begin
      $display("FAIL piecewise_linear_envelope_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
